>>> rtl/core/entity_metadata_stream_parser_defines.svh
// Assertion macros for the entity metadata stream parser.
`ifndef ENTITY_METADATA_STREAM_PARSER_DEFINES_SVH
`define ENTITY_METADATA_STREAM_PARSER_DEFINES_SVH
`ifndef SYNTH
`define EMSP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define EMSP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define EMSP_ASSERT(label, clk, rst_n, prop)
`define EMSP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/emsp_pkg.sv
// Shared types and constants of the entity metadata stream parser.
`timescale 1ns / 1ps
package emsp_pkg;
  localparam logic [3:0] PH_INDEX = 4'd0;
  localparam logic [3:0] PH_TYPE = 4'd1;
  localparam logic [3:0] PH_BYTE = 4'd2;
  localparam logic [3:0] PH_BOOL = 4'd3;
  localparam logic [3:0] PH_RAW32 = 4'd4;
  localparam logic [3:0] PH_VARINT = 4'd5;
  localparam logic [3:0] PH_CHARS = 4'd6;
  localparam logic [3:0] PH_END = 4'd7;
  localparam logic [3:0] PH_ERR = 4'd8;

  localparam logic [2:0] K_BYTE = 3'd0;
  localparam logic [2:0] K_VARINT = 3'd1;
  localparam logic [2:0] K_FLOAT = 3'd2;
  localparam logic [2:0] K_STRING = 3'd3;
  localparam logic [2:0] K_BOOL = 3'd4;
  localparam logic [2:0] K_POS = 3'd5;
  localparam logic [2:0] K_ROT = 3'd6;

  // Type codes as they appear on the wire.
  localparam logic [7:0] WT_BYTE = 8'd0;
  localparam logic [7:0] WT_VARINT = 8'd1;
  localparam logic [7:0] WT_FLOAT = 8'd2;
  localparam logic [7:0] WT_STRING = 8'd3;
  localparam logic [7:0] WT_BOOL = 8'd7;
  localparam logic [7:0] WT_ROT = 8'd8;
  localparam logic [7:0] WT_POS = 8'd9;

  localparam logic [2:0] ST_ELEM = 3'd0;
  localparam logic [2:0] ST_ENDMARK = 3'd1;
  localparam logic [2:0] ST_CLEAN = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_BADTYPE = 3'd4;
  localparam logic [2:0] ST_OVERLONG = 3'd5;

  localparam logic [7:0] END_INDEX = 8'hFF;
  localparam logic [14:0] MAX_LEN_RESET = 15'h7FFF;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]  entry_index;
    logic [2:0]  kind;
    logic [14:0] element_pos;
    logic [31:0] value;
    logic        element_last;
    logic        empty_payload;
    logic [2:0]  status;
    logic        stream_end;
  } result_t;

  // Classified byte that the front hands to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_end;
  } token_t;
endpackage

>>> rtl/core/emsp_if.sv
// Valid/ready channel interfaces of the entity metadata stream parser.
`timescale 1ns / 1ps
interface emsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface emsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  entry_index;
  logic [2:0]  kind;
  logic [14:0] element_pos;
  logic [31:0] value;
  logic        element_last;
  logic        empty_payload;
  logic [2:0]  status;
  logic        stream_end;
  modport source (output valid, entry_index, kind, element_pos, value, element_last,
                  empty_payload, status, stream_end, input ready);
  modport sink (input valid, entry_index, kind, element_pos, value, element_last,
                empty_payload, status, stream_end, output ready);
endinterface

interface emsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] max_string_len;
  modport source (output valid, max_string_len, input ready);
  modport sink (input valid, max_string_len, output ready);
endinterface

>>> rtl/core/emsp_front.sv
// Front end: accepts bytes, marks end-of-list bytes and queues them for the back.
`timescale 1ns / 1ps
module emsp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output logic                   tok_valid,
  input  logic                   tok_ready,
  output emsp_pkg::token_t       tok
);
  // Two-entry queue of classified bytes in front of the back end.
  emsp_pkg::token_t q_r [emsp_pkg::QUEUE_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_r, rd_r;
  logic       push, pop;

  assign in_ready = cnt_r != 2'(emsp_pkg::QUEUE_DEPTH);
  assign push = in_valid && in_ready;
  assign tok_valid = cnt_r != 2'd0;
  assign pop = tok_valid && tok_ready;
  assign tok = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r <= 1'b0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= '{data: in_byte, last: in_last, is_end: in_byte == emsp_pkg::END_INDEX};
    end
  end
endmodule

>>> rtl/core/emsp_back.sv
// Back end: parse state machine and output skid register.
`timescale 1ns / 1ps
module emsp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tok_valid,
  output logic                   tok_ready,
  input  emsp_pkg::token_t       tok,
  input  logic [14:0]            max_len,
  output logic                   out_valid,
  input  logic                   out_ready,
  output emsp_pkg::result_t      res
);
  logic [3:0]  ph_r, ph_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  grp_r, grp_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic [14:0] left_r, left_nxt;
  logic [14:0] ccnt_r, ccnt_nxt;
  logic        stop_r, stop_nxt;
  logic        ov_r;
  emsp_pkg::result_t ob_r, r;
  logic        emit, fire;
  logic [31:0] grp7, racc;
  logic [3:0]  grp1;

  assign tok_ready = !ov_r || out_ready;
  assign fire = tok_valid && tok_ready;
  assign out_valid = ov_r;
  assign res = ob_r;

  always_comb begin
    grp7 = 32'({tok.data[6:0]}) << ({2'b00, grp_r} * 5'd7);
    racc = acc_r | (32'(tok.data) << {grp_r[1:0], 3'b000});
    grp1 = {1'b0, grp_r} + 4'd1;
  end

  always_comb begin
    ph_nxt = ph_r; idx_nxt = idx_r; kind_nxt = kind_r; acc_nxt = acc_r;
    grp_nxt = grp_r; comp_nxt = comp_r; left_nxt = left_r; ccnt_nxt = ccnt_r;
    stop_nxt = stop_r; emit = 1'b0; r = '0;
    if (stop_r) begin
      if (tok.last) begin
        if (ph_r == emsp_pkg::PH_END) begin
          emit = 1'b1;
          r.status = emsp_pkg::ST_CLEAN;
        end
      end
    end else begin
      case (ph_r)
        emsp_pkg::PH_INDEX: begin
          if (tok.is_end) begin
            emit = 1'b1; r.status = emsp_pkg::ST_ENDMARK;
            stop_nxt = 1'b1; ph_nxt = emsp_pkg::PH_END;
          end else begin
            idx_nxt = tok.data; kind_nxt = emsp_pkg::K_BYTE; ph_nxt = emsp_pkg::PH_TYPE;
          end
        end
        emsp_pkg::PH_TYPE: begin
          acc_nxt = '0; grp_nxt = '0; comp_nxt = '0;
          case (tok.data)
            emsp_pkg::WT_BYTE: begin
              kind_nxt = emsp_pkg::K_BYTE; ph_nxt = emsp_pkg::PH_BYTE;
            end
            emsp_pkg::WT_VARINT: begin
              kind_nxt = emsp_pkg::K_VARINT; ph_nxt = emsp_pkg::PH_VARINT;
            end
            emsp_pkg::WT_FLOAT: begin
              kind_nxt = emsp_pkg::K_FLOAT; ph_nxt = emsp_pkg::PH_RAW32;
            end
            emsp_pkg::WT_STRING: begin
              kind_nxt = emsp_pkg::K_STRING; ph_nxt = emsp_pkg::PH_VARINT;
            end
            emsp_pkg::WT_BOOL: begin
              kind_nxt = emsp_pkg::K_BOOL; ph_nxt = emsp_pkg::PH_BOOL;
            end
            emsp_pkg::WT_ROT: begin
              kind_nxt = emsp_pkg::K_ROT; ph_nxt = emsp_pkg::PH_RAW32;
            end
            emsp_pkg::WT_POS: begin
              kind_nxt = emsp_pkg::K_POS; ph_nxt = emsp_pkg::PH_VARINT;
            end
            default: begin
              kind_nxt = emsp_pkg::K_BYTE; emit = 1'b1;
              r.entry_index = idx_r; r.status = emsp_pkg::ST_BADTYPE;
              stop_nxt = 1'b1; ph_nxt = emsp_pkg::PH_ERR;
            end
          endcase
        end
        emsp_pkg::PH_BYTE: begin
          emit = 1'b1; r.entry_index = idx_r; r.kind = emsp_pkg::K_BYTE;
          r.value = {{24{tok.data[7]}}, tok.data}; r.element_last = 1'b1;
          ph_nxt = emsp_pkg::PH_INDEX;
        end
        emsp_pkg::PH_BOOL: begin
          emit = 1'b1; r.entry_index = idx_r; r.kind = emsp_pkg::K_BOOL;
          r.value = {31'd0, tok.data != 8'd0}; r.element_last = 1'b1;
          ph_nxt = emsp_pkg::PH_INDEX;
        end
        emsp_pkg::PH_RAW32: begin
          acc_nxt = racc; grp_nxt = grp1[2:0];
          if (grp1 >= 4'd4) begin
            emit = 1'b1; r.entry_index = idx_r; r.kind = kind_r;
            r.element_pos = 15'(comp_r); r.value = racc;
            r.element_last = (kind_r == emsp_pkg::K_FLOAT) || (comp_r != 2'd0);
            if (r.element_last) begin
              ph_nxt = emsp_pkg::PH_INDEX;
            end else begin
              comp_nxt = comp_r + 2'd1; acc_nxt = '0; grp_nxt = '0;
            end
          end
        end
        emsp_pkg::PH_VARINT: begin
          acc_nxt = (grp_r < 3'd5) ? (acc_r | grp7) : acc_r;
          grp_nxt = (grp_r == 3'd7) ? grp_r : grp1[2:0];
          if (tok.data[7]) begin
            if (grp1 >= 4'd5) begin
              emit = 1'b1; r.entry_index = idx_r; r.kind = kind_r;
              r.status = emsp_pkg::ST_OVERLONG; stop_nxt = 1'b1; ph_nxt = emsp_pkg::PH_ERR;
            end
          end else if (kind_r == emsp_pkg::K_VARINT) begin
            emit = 1'b1; r.entry_index = idx_r; r.kind = kind_r; r.value = acc_nxt;
            r.element_last = 1'b1; ph_nxt = emsp_pkg::PH_INDEX;
          end else if (kind_r == emsp_pkg::K_POS) begin
            emit = 1'b1; r.entry_index = idx_r; r.kind = kind_r; r.value = acc_nxt;
            r.element_pos = 15'(comp_r); r.element_last = comp_r >= 2'd2;
            if (r.element_last) begin
              ph_nxt = emsp_pkg::PH_INDEX;
            end else begin
              comp_nxt = comp_r + 2'd1; acc_nxt = '0; grp_nxt = '0;
            end
          end else if (acc_nxt[31] || acc_nxt == 32'd0 || acc_nxt > 32'(max_len)) begin
            emit = 1'b1; r.entry_index = idx_r; r.kind = emsp_pkg::K_STRING;
            r.element_last = 1'b1; r.empty_payload = 1'b1; ph_nxt = emsp_pkg::PH_INDEX;
          end else begin
            left_nxt = acc_nxt[14:0]; ccnt_nxt = '0; ph_nxt = emsp_pkg::PH_CHARS;
          end
        end
        emsp_pkg::PH_CHARS: begin
          emit = 1'b1; r.entry_index = idx_r; r.kind = emsp_pkg::K_STRING;
          r.element_pos = ccnt_r; r.value = 32'(tok.data);
          r.element_last = left_r <= 15'd1; ccnt_nxt = ccnt_r + 15'd1;
          if (left_r <= 15'd1) begin
            left_nxt = '0; ph_nxt = emsp_pkg::PH_INDEX;
          end else begin
            left_nxt = left_r - 15'd1;
          end
        end
        default: ph_nxt = emsp_pkg::PH_INDEX;
      endcase
      if (tok.last && !stop_nxt && ph_nxt != emsp_pkg::PH_INDEX) begin
        emit = 1'b1; r = '0; r.entry_index = idx_nxt; r.kind = kind_nxt;
        r.status = emsp_pkg::ST_TRUNC;
      end
    end
    r.stream_end = tok.last;
    if (tok.last) begin
      ph_nxt = emsp_pkg::PH_INDEX; idx_nxt = '0; kind_nxt = '0; acc_nxt = '0;
      grp_nxt = '0; comp_nxt = '0; left_nxt = '0; ccnt_nxt = '0; stop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= emsp_pkg::PH_INDEX; idx_r <= '0; kind_r <= '0; acc_r <= '0;
      grp_r <= '0; comp_r <= '0; left_r <= '0; ccnt_r <= '0; stop_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (fire) begin
        ph_r <= ph_nxt; idx_r <= idx_nxt; kind_r <= kind_nxt; acc_r <= acc_nxt;
        grp_r <= grp_nxt; comp_r <= comp_nxt; left_r <= left_nxt; ccnt_r <= ccnt_nxt;
        stop_r <= stop_nxt;
      end
      if (fire) begin
        ov_r <= emit;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      ob_r <= r;
    end
  end
endmodule

>>> rtl/core/entity_metadata_stream_parser.sv
// Top level of the entity metadata stream parser.
// Usage: bytes of a metadata buffer enter on the in channel (in_byte, with
// in_last on the final byte). Each entry is an index byte, a type byte and
// a payload; index 0xFF ends the list. Results leave on the out channel,
// at most one per byte, with the entry index, kind, element position,
// value, status and a stream_end flag on the result of the final byte.
// The cfg channel writes max_string_len; write it only while idle.
// Path: an accepted byte passes a two-item queue and the parse state
// machine, and its result is registered in the output register.
// Throughput: one byte per cycle, sustained while the receiver takes results.
// Reset clears the parse state and sets max_string_len to 32767.
// When the receiver stalls the output register holds its item, the
// back stops taking bytes, the queue fills with two items and then
// in ready drops until the receiver takes the waiting result.
`timescale 1ns / 1ps
`include "entity_metadata_stream_parser_defines.svh"
module entity_metadata_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  emsp_in_if.sink     in_ch,
  emsp_out_if.source  out_ch,
  emsp_cfg_if.sink    cfg_ch
);
  logic [14:0] max_len_r;
  logic        tok_valid, tok_ready;
  logic        res_is_status, out_stalled;
  emsp_pkg::token_t  tok;
  emsp_pkg::result_t res;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= emsp_pkg::MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      max_len_r <= cfg_ch.max_string_len;
    end
  end

  emsp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.in_byte), .in_last(in_ch.in_last),
    .tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok)
  );

  emsp_back u_back (
    .clk(clk), .rst_n(rst_n), .tok_valid(tok_valid), .tok_ready(tok_ready), .tok(tok),
    .max_len(max_len_r), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .res(res)
  );

  assign out_ch.entry_index = res.entry_index;
  assign out_ch.kind = res.kind;
  assign out_ch.element_pos = res.element_pos;
  assign out_ch.value = res.value;
  assign out_ch.element_last = res.element_last;
  assign out_ch.empty_payload = res.empty_payload;
  assign out_ch.status = res.status;
  assign out_ch.stream_end = res.stream_end;

  assign res_is_status = out_ch.valid && (res.status != emsp_pkg::ST_ELEM);
  assign out_stalled = out_ch.valid && !out_ch.ready;

  `EMSP_ASSERT(a_err_fields_zero, clk, rst_n, res_is_status |-> (res.value == 32'd0 && !res.element_last))
  `EMSP_ASSERT(a_empty_is_last, clk, rst_n, (out_ch.valid && res.empty_payload) |-> res.element_last)
  `EMSP_ASSERT(a_out_held, clk, rst_n, out_stalled |=> (out_ch.valid && $stable(res)))
endmodule

>>> tb/tb_entity_metadata_stream_parser.sv
// Self-checking testbench for the entity metadata stream parser.
`timescale 1ns / 1ps
module tb_entity_metadata_stream_parser;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  emsp_in_if  in_ch ();
  emsp_out_if out_ch ();
  emsp_cfg_if cfg_ch ();

  entity_metadata_stream_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_string_len = '0;
  end

  wire_byte_t          byte_queue[$];
  emsp_pkg::result_t   expected_results[$];
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         results_seen = 0;
  int         cfg_writes = 0;
  bit         quiet = 1'b0;
  int         hold_request = 0;

  // Parser state mirrored for prediction.
  logic [3:0]  phase_q;
  logic [7:0]  index_q;
  logic [2:0]  kind_q;
  logic [31:0] acc_q;
  int          groups_q;
  int          comp_q;
  logic [14:0] left_q;
  logic [14:0] chars_q;
  bit          halted_q;
  logic [14:0] max_len_q;

  function automatic void rearm_parser();
    phase_q = emsp_pkg::PH_INDEX;
    index_q = '0;
    kind_q = '0;
    acc_q = '0;
    groups_q = 0;
    comp_q = 0;
    left_q = '0;
    chars_q = '0;
    halted_q = 1'b0;
  endfunction

  function automatic void raise_error(logic [2:0] code, output emsp_pkg::result_t r);
    r = '0;
    r.entry_index = index_q;
    r.kind = kind_q;
    r.status = code;
    halted_q = 1'b1;
    phase_q = emsp_pkg::PH_ERR;
  endfunction

  function automatic emsp_pkg::result_t element(logic [2:0] k, int pos, logic [31:0] v,
                                                bit lst);
    emsp_pkg::result_t r;
    r = '0;
    r.entry_index = index_q;
    r.kind = k;
    r.element_pos = 15'(pos);
    r.value = v;
    r.element_last = lst;
    r.status = emsp_pkg::ST_ELEM;
    return r;
  endfunction

  // Advances the mirrored parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                    output emsp_pkg::result_t r);
    bit got;
    bit lst;
    got = 1'b0;
    r = '0;
    if (halted_q) begin
      if (fin) begin
        if (phase_q == emsp_pkg::PH_END) begin
          r.status = emsp_pkg::ST_CLEAN;
          r.stream_end = 1'b1;
          got = 1'b1;
        end
        rearm_parser();
      end
      return got;
    end
    case (phase_q)
      emsp_pkg::PH_INDEX: begin
        if (b == emsp_pkg::END_INDEX) begin
          r.status = emsp_pkg::ST_ENDMARK;
          got = 1'b1;
          halted_q = 1'b1;
          phase_q = emsp_pkg::PH_END;
        end else begin
          index_q = b;
          kind_q = emsp_pkg::K_BYTE;
          phase_q = emsp_pkg::PH_TYPE;
        end
      end
      emsp_pkg::PH_TYPE: begin
        acc_q = '0;
        groups_q = 0;
        comp_q = 0;
        case (b)
          emsp_pkg::WT_BYTE: begin
            kind_q = emsp_pkg::K_BYTE; phase_q = emsp_pkg::PH_BYTE;
          end
          emsp_pkg::WT_VARINT: begin
            kind_q = emsp_pkg::K_VARINT; phase_q = emsp_pkg::PH_VARINT;
          end
          emsp_pkg::WT_FLOAT: begin
            kind_q = emsp_pkg::K_FLOAT; phase_q = emsp_pkg::PH_RAW32;
          end
          emsp_pkg::WT_STRING: begin
            kind_q = emsp_pkg::K_STRING; phase_q = emsp_pkg::PH_VARINT;
          end
          emsp_pkg::WT_BOOL: begin
            kind_q = emsp_pkg::K_BOOL; phase_q = emsp_pkg::PH_BOOL;
          end
          emsp_pkg::WT_ROT: begin
            kind_q = emsp_pkg::K_ROT; phase_q = emsp_pkg::PH_RAW32;
          end
          emsp_pkg::WT_POS: begin
            kind_q = emsp_pkg::K_POS; phase_q = emsp_pkg::PH_VARINT;
          end
          default: begin
            kind_q = emsp_pkg::K_BYTE;
            raise_error(emsp_pkg::ST_BADTYPE, r);
            got = 1'b1;
          end
        endcase
      end
      emsp_pkg::PH_BYTE: begin
        r = element(emsp_pkg::K_BYTE, 0, {{24{b[7]}}, b}, 1'b1);
        got = 1'b1;
        phase_q = emsp_pkg::PH_INDEX;
      end
      emsp_pkg::PH_BOOL: begin
        r = element(emsp_pkg::K_BOOL, 0, (b != 8'd0) ? 32'd1 : 32'd0, 1'b1);
        got = 1'b1;
        phase_q = emsp_pkg::PH_INDEX;
      end
      emsp_pkg::PH_RAW32: begin
        acc_q = acc_q | (32'(b) << (groups_q[1:0] * 8));
        groups_q++;
        if (groups_q >= 4) begin
          lst = (kind_q == emsp_pkg::K_FLOAT) || (comp_q >= 1);
          r = element(kind_q, comp_q, acc_q, lst);
          got = 1'b1;
          if (lst) begin
            phase_q = emsp_pkg::PH_INDEX;
          end else begin
            comp_q++;
            acc_q = '0;
            groups_q = 0;
          end
        end
      end
      emsp_pkg::PH_VARINT: begin
        if (groups_q < 5) acc_q = acc_q | (32'(b[6:0]) << (groups_q * 7));
        groups_q++;
        if (b[7]) begin
          if (groups_q >= 5) begin
            raise_error(emsp_pkg::ST_OVERLONG, r);
            got = 1'b1;
          end
        end else if (kind_q == emsp_pkg::K_VARINT) begin
          r = element(emsp_pkg::K_VARINT, 0, acc_q, 1'b1);
          got = 1'b1;
          phase_q = emsp_pkg::PH_INDEX;
        end else if (kind_q == emsp_pkg::K_POS) begin
          lst = comp_q >= 2;
          r = element(emsp_pkg::K_POS, comp_q, acc_q, lst);
          got = 1'b1;
          if (lst) begin
            phase_q = emsp_pkg::PH_INDEX;
          end else begin
            comp_q++;
            acc_q = '0;
            groups_q = 0;
          end
        end else if (acc_q[31] || acc_q == 32'd0 || acc_q > 32'(max_len_q)) begin
          r = element(emsp_pkg::K_STRING, 0, 32'd0, 1'b1);
          r.empty_payload = 1'b1;
          got = 1'b1;
          phase_q = emsp_pkg::PH_INDEX;
        end else begin
          left_q = acc_q[14:0];
          chars_q = '0;
          phase_q = emsp_pkg::PH_CHARS;
        end
      end
      emsp_pkg::PH_CHARS: begin
        r = element(emsp_pkg::K_STRING, int'(chars_q), 32'(b), left_q <= 15'd1);
        got = 1'b1;
        chars_q = chars_q + 15'd1;
        if (left_q <= 15'd1) begin
          left_q = '0;
          phase_q = emsp_pkg::PH_INDEX;
        end else begin
          left_q = left_q - 15'd1;
        end
      end
      default: phase_q = emsp_pkg::PH_INDEX;
    endcase
    if (fin) begin
      if (!halted_q && phase_q != emsp_pkg::PH_INDEX) begin
        r = '0;
        r.entry_index = index_q;
        r.kind = kind_q;
        r.status = emsp_pkg::ST_TRUNC;
        got = 1'b1;
      end
      if (got) r.stream_end = 1'b1;
      rearm_parser();
    end
    return got;
  endfunction

  // Sender: accepted items feed the predictor, then the next item is offered.
  int send_gap = 0;
  always @(posedge clk) begin
    emsp_pkg::result_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      rearm_parser();
      max_len_q = emsp_pkg::MAX_LEN_RESET;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bytes_sent++;
        if (parse_byte(in_ch.in_byte, in_ch.in_last, r)) begin
          expected_results.insert(expected_results.size(), r);
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (!quiet && byte_queue.size() > 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          in_ch.valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          wire_byte_t w;
          w = byte_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= w.data;
          in_ch.in_last <= w.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts plus a long hold-off each time hold_request changes.
  int stall_left = 0;
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = 120;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)", field, got, want,
             results_seen);
  endtask

  always @(posedge clk) begin
    emsp_pkg::result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected result", 32'(out_ch.status), 32'd0);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.entry_index !== e.entry_index)
          report("entry_index", 32'(out_ch.entry_index), 32'(e.entry_index));
        if (out_ch.kind !== e.kind) report("kind", 32'(out_ch.kind), 32'(e.kind));
        if (out_ch.element_pos !== e.element_pos)
          report("element_pos", 32'(out_ch.element_pos), 32'(e.element_pos));
        if (out_ch.value !== e.value) report("value", out_ch.value, e.value);
        if (out_ch.element_last !== e.element_last)
          report("element_last", 32'(out_ch.element_last), 32'(e.element_last));
        if (out_ch.empty_payload !== e.empty_payload)
          report("empty_payload", 32'(out_ch.empty_payload), 32'(e.empty_payload));
        if (out_ch.status !== e.status)
          report("status", 32'(out_ch.status), 32'(e.status));
        if (out_ch.stream_end !== e.stream_end)
          report("stream_end", 32'(out_ch.stream_end), 32'(e.stream_end));
      end
    end
  end

  // Stimulus helpers.
  logic [14:0] gen_max = emsp_pkg::MAX_LEN_RESET;

  task automatic push_buffer(logic [7:0] bytes[$]);
    wire_byte_t w;
    foreach (bytes[i]) begin
      w.data = bytes[i];
      w.last = (i == bytes.size() - 1);
      byte_queue.insert(byte_queue.size(), w);
    end
  endtask

  function automatic void add_varint(ref logic [7:0] q[$], input logic [31:0] v);
    logic [7:0] g;
    do begin
      g = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) g[7] = 1'b1;
      q.insert(q.size(), g);
    end while (v != 0);
  endfunction

  function automatic void add_entry(ref logic [7:0] q[$]);
    int sel;
    logic [31:0] len;
    q.insert(q.size(), 8'($urandom_range(0, 254)));
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1: begin
        q.insert(q.size(), emsp_pkg::WT_BYTE);
        q.insert(q.size(), 8'($urandom));
      end
      2, 3: begin
        q.insert(q.size(), emsp_pkg::WT_VARINT);
        add_varint(q, $urandom >> $urandom_range(0, 31));
      end
      4, 5: begin
        q.insert(q.size(), emsp_pkg::WT_FLOAT);
        repeat (4) q.insert(q.size(), 8'($urandom));
      end
      6, 7, 8: begin
        q.insert(q.size(), emsp_pkg::WT_STRING);
        case ($urandom_range(0, 9))
          0: len = 32'd0;
          1: len = 32'(gen_max) + $urandom_range(1, 3);
          2: len = 32'h8000_0000 | $urandom;
          default: len = $urandom_range(1, 6);
        endcase
        add_varint(q, len);
        if (len != 0 && len <= 32'(gen_max)) repeat (len) q.insert(q.size(), 8'($urandom));
      end
      9, 10: begin
        q.insert(q.size(), emsp_pkg::WT_BOOL);
        q.insert(q.size(), $urandom_range(0, 1) ? 8'($urandom) : 8'd0);
      end
      11, 12: begin
        q.insert(q.size(), emsp_pkg::WT_ROT);
        repeat (8) q.insert(q.size(), 8'($urandom));
      end
      13, 14, 15: begin
        q.insert(q.size(), emsp_pkg::WT_POS);
        repeat (3) add_varint(q, $urandom >> $urandom_range(0, 31));
      end
      16: begin
        // Varint whose fifth group still carries a continuation bit.
        q.insert(q.size(), $urandom_range(0, 1) ? emsp_pkg::WT_VARINT : emsp_pkg::WT_POS);
        repeat (5) q.insert(q.size(), 8'($urandom) | 8'h80);
      end
      17: q.insert(q.size(), 8'($urandom_range(10, 255)));
      default: begin
        q.insert(q.size(), emsp_pkg::WT_BYTE);
        q.insert(q.size(), 8'($urandom));
      end
    endcase
  endfunction

  task automatic random_buffer();
    logic [7:0] q[$];
    int ending;
    repeat ($urandom_range(1, 6)) add_entry(q);
    ending = $urandom_range(0, 3);
    if (ending == 0) begin
      q.insert(q.size(), emsp_pkg::END_INDEX);
      repeat ($urandom_range(0, 3)) q.insert(q.size(), 8'($urandom));
    end else if (ending == 1) begin
      // Cut the buffer short at a random point, so the final byte may land inside an entry.
      q = q[0:$urandom_range(0, q.size() - 1)];
    end
    push_buffer(q);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(logic [14:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_string_len <= v;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    max_len_q = v;
    gen_max = v;
    cfg_writes++;
  endtask

  task automatic random_phase(int n_items);
    int target;
    target = bytes_sent + byte_queue.size() + n_items;
    while (bytes_sent + byte_queue.size() < target) begin
      random_buffer();
      if (byte_queue.size() > 64) wait (byte_queue.size() < 16);
    end
    wait_drained();
  endtask

  initial begin
    logic [7:0] d[$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every type with edge values, then each error case.
    d = {8'd0, emsp_pkg::WT_BYTE, 8'h80, 8'd1, emsp_pkg::WT_BYTE, 8'h7F,
         8'd254, emsp_pkg::WT_VARINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
         8'd2, emsp_pkg::WT_VARINT, 8'h00,
         8'd3, emsp_pkg::WT_FLOAT, 8'h00, 8'h00, 8'h80, 8'hFF};
    push_buffer(d);
    d = {8'd4, emsp_pkg::WT_STRING, 8'h03, "a", "b", "c",
         8'd5, emsp_pkg::WT_STRING, 8'h00,
         8'd6, emsp_pkg::WT_BOOL, 8'h00, 8'd7, emsp_pkg::WT_BOOL, 8'hFF,
         8'd8, emsp_pkg::WT_POS, 8'h01, 8'hFF, 8'h7F, 8'h80, 8'h80, 8'h80, 8'h80, 8'h0F,
         8'd9, emsp_pkg::WT_ROT, 8'h01, 8'h02, 8'h03, 8'h04, 8'hF5, 8'hF6, 8'hF7, 8'hF8,
         8'd10, emsp_pkg::WT_STRING, 8'h80, 8'h80, 8'h80, 8'h80, 8'h08,
         emsp_pkg::END_INDEX, 8'h55, 8'hAA};
    push_buffer(d);
    d = {8'd11, 8'd5, 8'h00, 8'h01};
    push_buffer(d);
    d = {8'd12, emsp_pkg::WT_VARINT, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
    push_buffer(d);
    d = {8'd13};
    push_buffer(d);
    wait_drained();

    write_max_len(15'd0);
    random_phase(300);
    write_max_len(15'd4);
    random_phase(200);
    // The receiver holds off while bytes keep coming, then the sender pauses.
    hold_request++;
    random_phase(200);
    random_phase(150);
    write_max_len(15'($urandom_range(1, 32766)));
    random_phase(400);
    write_max_len(15'h7FFF);
    random_phase(500);
    quiet = 1'b1;
    random_phase(300);

    $display("Sent %0d bytes, checked %0d results across %0d max_string_len settings.",
             bytes_sent, results_seen, cfg_writes);
    if (mismatches == 0) begin
      $display("entity_metadata_stream_parser test passed");
    end else begin
      $display("entity_metadata_stream_parser test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("entity_metadata_stream_parser test failed");
    $finish;
  end
endmodule

>>> entity_metadata_stream_parser.f
+incdir+rtl/core
rtl/core/emsp_pkg.sv
rtl/core/emsp_if.sv
rtl/core/emsp_front.sv
rtl/core/emsp_back.sv
rtl/core/entity_metadata_stream_parser.sv
tb/tb_entity_metadata_stream_parser.sv
